@@ rtl/arc_pkg.sv @@
// Package: shared constants, result codes and controller/datapath interface types.
`default_nettype none
package arc_pkg;
	localparam int CACHE_ENTRIES = 16;
	localparam int QUEUE_ENTRIES = 8;
	localparam int TAG_BITS      = 8;
	localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int QIDX_W = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
	localparam int QCNT_W = $clog2(QUEUE_ENTRIES + 1);
	localparam int STAMP_W = 8;

	localparam logic [15:0] OP_REQUEST = 16'h0001;
	localparam logic [15:0] OP_REPLY   = 16'h0002;

	localparam logic [1:0] REG_OWN_IP   = 2'd0;
	localparam logic [1:0] REG_OWN_MAC  = 2'd1;
	localparam logic [1:0] REG_IP_VALID = 2'd2;

	typedef enum logic [2:0] {
		KIND_HIT      = 3'd0,
		KIND_QUEUED   = 3'd1,
		KIND_FULL     = 3'd2,
		KIND_REFUSED  = 3'd3,
		KIND_REPLY    = 3'd4,
		KIND_RELEASE  = 3'd5
	} kind_t;

	typedef struct packed {
		logic  capture;
		logic  cscan_clr;
		logic  cscan_step;
		logic  cache_write;
		logic  qscan_clr;
		logic  qscan_step;
		logic  q_enqueue;
		logic  q_release;
		logic  emit;
		kind_t emit_kind;
	} cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic op_req;
		logic op_reply;
		logic for_us;
		logic ip_valid;
		logic cache_hit;
		logic cscan_last;
		logic qscan_last;
		logic qcount_zero;
		logic q_free;
		logic out_free;
	} status_t;
endpackage
`default_nettype wire

@@ rtl/arc_ctrl.sv @@
// Controller: sequences capture, cache scan, queue scan and result beats.
`default_nettype none
module arc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  arc_pkg::status_t st,
	output arc_pkg::cmd_t    cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_REPLY, S_CSCAN, S_DECIDE, S_QSCAN, S_QEVAL
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.emit_kind = arc_pkg::KIND_HIT;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.cscan_clr = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.is_lookup || st.op_reply)
					state_d = S_CSCAN;
				else if (st.op_req && st.for_us)
					state_d = S_REPLY;
				else
					state_d = S_IDLE;
			end
			S_REPLY: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = arc_pkg::KIND_REPLY;
					state_d = S_CSCAN;
				end
			end
			S_CSCAN: begin
				cmd.cscan_step = 1'b1;
				if (st.cscan_last)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (st.is_lookup) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						state_d = S_IDLE;
						if (st.cache_hit)
							cmd.emit_kind = arc_pkg::KIND_HIT;
						else if (!st.ip_valid)
							cmd.emit_kind = arc_pkg::KIND_REFUSED;
						else if (st.q_free) begin
							cmd.emit_kind = arc_pkg::KIND_QUEUED;
							cmd.q_enqueue = 1'b1;
						end else
							cmd.emit_kind = arc_pkg::KIND_FULL;
					end
				end else begin
					cmd.cache_write = 1'b1;
					cmd.qscan_clr = 1'b1;
					state_d = st.op_reply ? S_QSCAN : S_IDLE;
				end
			end
			S_QSCAN: begin
				cmd.qscan_step = 1'b1;
				if (st.qscan_last)
					state_d = S_QEVAL;
			end
			S_QEVAL: begin
				if (st.qcount_zero)
					state_d = S_IDLE;
				else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = arc_pkg::KIND_RELEASE;
					cmd.q_release = 1'b1;
					cmd.qscan_clr = 1'b1;
					state_d = S_QSCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

@@ rtl/arc_datapath.sv @@
// Datapath: configuration, captured item, cache, pending queue and output register.
`default_nettype none
module arc_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire  [1:0]                   cfg_index,
	input  wire  [47:0]                  cfg_data,
	input  wire                          req_type,
	input  wire  [15:0]                  arp_op,
	input  wire  [47:0]                  sender_mac,
	input  wire  [31:0]                  sender_ip,
	input  wire  [31:0]                  target_ip,
	input  wire  [31:0]                  lookup_ip,
	input  wire  [arc_pkg::TAG_BITS-1:0] packet_tag,
	input  wire                          out_stall,
	output logic                         out_valid,
	output logic [2:0]                   out_kind,
	output logic [47:0]                  dst_mac,
	output logic [31:0]                  arp_target_ip,
	output logic [31:0]                  arp_source_ip,
	output logic [arc_pkg::TAG_BITS-1:0] release_tag,
	output logic                         last,
	input  arc_pkg::cmd_t                cmd,
	output arc_pkg::status_t             st
);
	localparam int CE = arc_pkg::CACHE_ENTRIES;
	localparam int QE = arc_pkg::QUEUE_ENTRIES;
	localparam int CW = arc_pkg::CIDX_W;
	localparam int QW = arc_pkg::QIDX_W;
	localparam int NW = arc_pkg::QCNT_W;
	localparam int SW = arc_pkg::STAMP_W;
	localparam int TW = arc_pkg::TAG_BITS;

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic        ip_valid_q;

	logic          req_type_q;
	logic [15:0]   op_q;
	logic [47:0]   smac_q;
	logic [31:0]   sip_q, tip_q, lip_q;
	logic [TW-1:0] tag_q;

	logic [31:0]   cache_ip_q  [CE];
	logic [47:0]   cache_mac_q [CE];
	logic [CE-1:0] cache_valid_q;
	logic [CW-1:0] next_slot_q;
	logic [CW-1:0] cidx_q, hit_idx_q;
	logic          hit_q;

	logic [31:0]   queue_ip_q    [QE];
	logic [TW-1:0] queue_tag_q   [QE];
	logic [SW-1:0] queue_stamp_q [QE];
	logic [QE-1:0] queue_valid_q;
	logic [SW-1:0] stamp_q;
	logic [QW-1:0] qidx_q, best_idx_q;
	logic [SW-1:0] best_age_q;
	logic [NW-1:0] qcount_q;

	logic          out_valid_q;
	logic [31:0]   key_ip;
	logic          cmatch, qmatch;
	logic [SW-1:0] qage;
	logic          free_found;
	logic [QW-1:0] free_idx;

	assign key_ip = req_type_q ? lip_q : sip_q;
	assign cmatch = cache_valid_q[cidx_q] && (cache_ip_q[cidx_q] == key_ip);
	assign qmatch = queue_valid_q[qidx_q] && (queue_ip_q[qidx_q] == sip_q);
	assign qage   = stamp_q - SW'(1) - queue_stamp_q[qidx_q];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = QE - 1; i >= 0; i--) begin
			if (!queue_valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = QW'(i);
			end
		end
	end

	always_comb begin
		st.is_lookup   = req_type_q;
		st.op_req      = (op_q == arc_pkg::OP_REQUEST);
		st.op_reply    = (op_q == arc_pkg::OP_REPLY);
		st.for_us      = ip_valid_q && (tip_q == own_ip_q);
		st.ip_valid    = ip_valid_q;
		st.cache_hit   = hit_q;
		st.cscan_last  = (cidx_q == CW'(CE - 1));
		st.qscan_last  = (qidx_q == QW'(QE - 1));
		st.qcount_zero = (qcount_q == '0);
		st.q_free      = free_found;
		st.out_free    = !out_valid_q || !out_stall;
	end

	// configuration and captured item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q   <= '0;
			own_mac_q  <= '0;
			ip_valid_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				arc_pkg::REG_OWN_IP:   own_ip_q   <= cfg_data[31:0];
				arc_pkg::REG_OWN_MAC:  own_mac_q  <= cfg_data;
				arc_pkg::REG_IP_VALID: ip_valid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			op_q       <= arp_op;
			smac_q     <= sender_mac;
			sip_q      <= sender_ip;
			tip_q      <= target_ip;
			lip_q      <= lookup_ip;
			tag_q      <= packet_tag;
		end
	end

	// cache: one entry compared per cycle, first match kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_valid_q <= '0;
			next_slot_q   <= '0;
			cidx_q        <= '0;
			hit_q         <= 1'b0;
			hit_idx_q     <= '0;
		end else begin
			if (cmd.cscan_clr) begin
				cidx_q <= '0;
				hit_q  <= 1'b0;
			end else if (cmd.cscan_step) begin
				cidx_q <= (cidx_q == CW'(CE - 1)) ? '0 : cidx_q + CW'(1);
				if (cmatch && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cidx_q;
				end
			end
			if (cmd.cache_write && !hit_q) begin
				cache_valid_q[next_slot_q] <= 1'b1;
				next_slot_q <= (next_slot_q == CW'(CE - 1)) ? '0 : next_slot_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cache_write) begin
			if (hit_q)
				cache_mac_q[hit_idx_q] <= smac_q;
			else begin
				cache_ip_q[next_slot_q]  <= sip_q;
				cache_mac_q[next_slot_q] <= smac_q;
			end
		end
	end

	// pending queue: newest matching entry found by a sweep, matches counted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_valid_q <= '0;
			stamp_q       <= '0;
			qidx_q        <= '0;
			qcount_q      <= '0;
			best_idx_q    <= '0;
			best_age_q    <= '0;
		end else begin
			if (cmd.q_enqueue) begin
				queue_valid_q[free_idx] <= 1'b1;
				stamp_q <= stamp_q + SW'(1);
			end
			if (cmd.q_release)
				queue_valid_q[best_idx_q] <= 1'b0;
			if (cmd.qscan_clr) begin
				qidx_q   <= '0;
				qcount_q <= '0;
			end else if (cmd.qscan_step) begin
				qidx_q <= (qidx_q == QW'(QE - 1)) ? '0 : qidx_q + QW'(1);
				if (qmatch) begin
					qcount_q <= qcount_q + NW'(1);
					if (qcount_q == '0 || qage < best_age_q) begin
						best_idx_q <= qidx_q;
						best_age_q <= qage;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_enqueue) begin
			queue_ip_q[free_idx]    <= lip_q;
			queue_tag_q[free_idx]   <= tag_q;
			queue_stamp_q[free_idx] <= stamp_q;
		end
	end

	// output register: load a beat, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind <= cmd.emit_kind;
			case (cmd.emit_kind)
				arc_pkg::KIND_HIT: begin
					dst_mac       <= cache_mac_q[hit_idx_q];
					arp_target_ip <= '0;
					arp_source_ip <= '0;
					release_tag   <= tag_q;
					last          <= 1'b1;
				end
				arc_pkg::KIND_QUEUED, arc_pkg::KIND_FULL: begin
					dst_mac       <= '1;
					arp_target_ip <= lip_q;
					arp_source_ip <= own_ip_q;
					release_tag   <= tag_q;
					last          <= 1'b1;
				end
				arc_pkg::KIND_REPLY: begin
					dst_mac       <= smac_q;
					arp_target_ip <= sip_q;
					arp_source_ip <= own_ip_q;
					release_tag   <= '0;
					last          <= 1'b1;
				end
				arc_pkg::KIND_RELEASE: begin
					dst_mac       <= smac_q;
					arp_target_ip <= '0;
					arp_source_ip <= '0;
					release_tag   <= queue_tag_q[best_idx_q];
					last          <= (qcount_q == NW'(1));
				end
				default: begin
					dst_mac       <= '0;
					arp_target_ip <= '0;
					arp_source_ip <= '0;
					release_tag   <= tag_q;
					last          <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// own MAC is held for the register map; no output of this block carries it
	logic own_mac_unused;
	assign own_mac_unused = ^own_mac_q;
endmodule
`default_nettype wire

@@ rtl/arp_resolver_cache.sv @@
// Top level: ARP cache and responder for one interface.
//
// Input channel (in_valid/in_stall) takes one beat per item: a received ARP
// packet (req_type 0) or an address lookup (req_type 1). Output channel
// (out_valid/out_stall) returns result beats; last marks the final beat of
// an item. A received request for us gives one reply beat; a reply gives one
// release beat per waiting tag, newest first; a lookup gives exactly one beat.
// Configuration writes (cfg_valid/cfg_ready, always ready) set own_ip, own_mac
// and ip_valid by index; the user must make them only while the block is idle,
// as the block does not enforce it. One item is handled at a time; in_stall is
// high until it is finished. A lookup passes through capture, dispatch, a sweep
// of all cache entries and a decision step that loads its beat. A request for
// us loads its reply beat after dispatch, then sweeps the cache and learns the
// sender. A reply sweeps the cache and learns the sender, then per waiting tag
// sweeps the queue and loads a release beat; a sweep finding none ends it. Other
// items end after dispatch. A result held in the output register while the
// receiver stalls does not block the next input; a further beat waits until it is taken.
// Reset clears cache and queue valid bits, pointers and configuration.
`default_nettype none
module arp_resolver_cache (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [1:0]                   cfg_index,
	input  wire  [47:0]                  cfg_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          req_type,
	input  wire  [15:0]                  arp_op,
	input  wire  [47:0]                  sender_mac,
	input  wire  [31:0]                  sender_ip,
	input  wire  [31:0]                  target_ip,
	input  wire  [31:0]                  lookup_ip,
	input  wire  [arc_pkg::TAG_BITS-1:0] packet_tag,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [2:0]                   out_kind,
	output logic [47:0]                  dst_mac,
	output logic [31:0]                  arp_target_ip,
	output logic [31:0]                  arp_source_ip,
	output logic [arc_pkg::TAG_BITS-1:0] release_tag,
	output logic                         last
);
	arc_pkg::cmd_t    cmd;
	arc_pkg::status_t st;

	assign cfg_ready = 1'b1;

	arc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	arc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.arp_op        (arp_op),
		.sender_mac    (sender_mac),
		.sender_ip     (sender_ip),
		.target_ip     (target_ip),
		.lookup_ip     (lookup_ip),
		.packet_tag    (packet_tag),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_kind      (out_kind),
		.dst_mac       (dst_mac),
		.arp_target_ip (arp_target_ip),
		.arp_source_ip (arp_source_ip),
		.release_tag   (release_tag),
		.last          (last),
		.cmd           (cmd),
		.st            (st)
	);
endmodule
`default_nettype wire

@@ tb/tb_arp_resolver_cache.sv @@
// Testbench for arp_resolver_cache: drives random and directed ARP traffic and checks every result beat.
`default_nettype none
module tb_arp_resolver_cache;
	localparam int TB_TAG_W = arc_pkg::TAG_BITS;
	localparam int TB_CE    = arc_pkg::CACHE_ENTRIES;
	localparam int TB_QE    = arc_pkg::QUEUE_ENTRIES;

	typedef struct {
		bit                  req_type;
		logic [15:0]         arp_op;
		logic [47:0]         sender_mac;
		logic [31:0]         sender_ip;
		logic [31:0]         target_ip;
		logic [31:0]         lookup_ip;
		logic [TB_TAG_W-1:0] packet_tag;
	} arp_item_t;

	typedef struct {
		arc_pkg::kind_t      kind;
		logic [47:0]         mac;
		logic [31:0]         tip;
		logic [31:0]         sip;
		logic [TB_TAG_W-1:0] tag;
		bit                  last;
	} arp_beat_t;

	class arp_cache_board;
		logic [31:0]         own_ip;
		logic [47:0]         own_mac;
		bit                  ip_valid;
		logic [31:0]         c_ip [TB_CE];
		logic [47:0]         c_mac [TB_CE];
		bit                  c_valid [TB_CE];
		int                  c_next;
		logic [31:0]         q_ip [TB_QE];
		logic [TB_TAG_W-1:0] q_tag [TB_QE];
		bit                  q_valid [TB_QE];
		logic [7:0]          q_stamp [TB_QE];
		logic [7:0]          stamp;
		arp_beat_t           due_beats [$];
		int                  errors;
		int                  items_seen;
		int                  beats_seen;
		int                  kind_seen [8];

		function new();
			own_ip = 0;
			own_mac = 0;
			ip_valid = 0;
			c_next = 0;
			stamp = 0;
			errors = 0;
			items_seen = 0;
			beats_seen = 0;
			foreach (c_valid[i]) c_valid[i] = 0;
			foreach (q_valid[i]) q_valid[i] = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [47:0] data);
			case (idx)
				arc_pkg::REG_OWN_IP: own_ip = data[31:0];
				arc_pkg::REG_OWN_MAC: own_mac = data;
				arc_pkg::REG_IP_VALID: ip_valid = data[0];
				default: ;
			endcase
		endfunction

		function void push_beat(arc_pkg::kind_t k, logic [47:0] m, logic [31:0] t,
				logic [31:0] s, logic [TB_TAG_W-1:0] g, bit l);
			arp_beat_t b;
			b.kind = k;
			b.mac = m;
			b.tip = t;
			b.sip = s;
			b.tag = g;
			b.last = l;
			due_beats.push_back(b);
		endfunction

		function void learn_mac(logic [31:0] ip, logic [47:0] mac);
			for (int i = 0; i < TB_CE; i++) begin
				if (c_valid[i] && c_ip[i] == ip) begin
					c_mac[i] = mac;
					return;
				end
			end
			c_ip[c_next] = ip;
			c_mac[c_next] = mac;
			c_valid[c_next] = 1;
			c_next = (c_next + 1) % TB_CE;
		endfunction

		// Note an accepted input beat and queue the beats it should cause.
		function void note_item(arp_item_t it);
			int free_slot;
			int best;
			int n;
			logic [7:0] age;
			logic [7:0] best_age;
			items_seen++;
			if (it.req_type) begin
				for (int i = 0; i < TB_CE; i++) begin
					if (c_valid[i] && c_ip[i] == it.lookup_ip) begin
						push_beat(arc_pkg::KIND_HIT, c_mac[i], 0, 0, it.packet_tag, 1);
						return;
					end
				end
				if (!ip_valid) begin
					push_beat(arc_pkg::KIND_REFUSED, 0, 0, 0, it.packet_tag, 1);
					return;
				end
				free_slot = -1;
				for (int i = TB_QE - 1; i >= 0; i--)
					if (!q_valid[i]) free_slot = i;
				if (free_slot >= 0) begin
					q_valid[free_slot] = 1;
					q_ip[free_slot] = it.lookup_ip;
					q_tag[free_slot] = it.packet_tag;
					q_stamp[free_slot] = stamp;
					stamp = stamp + 8'd1;
					push_beat(arc_pkg::KIND_QUEUED, '1, it.lookup_ip, own_ip, it.packet_tag, 1);
				end else begin
					push_beat(arc_pkg::KIND_FULL, '1, it.lookup_ip, own_ip, it.packet_tag, 1);
				end
			end else if (it.arp_op == arc_pkg::OP_REQUEST) begin
				if (ip_valid && it.target_ip == own_ip) begin
					push_beat(arc_pkg::KIND_REPLY, it.sender_mac, it.sender_ip, own_ip, 0, 1);
					learn_mac(it.sender_ip, it.sender_mac);
				end
			end else if (it.arp_op == arc_pkg::OP_REPLY) begin
				learn_mac(it.sender_ip, it.sender_mac);
				n = 0;
				forever begin
					best = -1;
					best_age = 0;
					for (int i = 0; i < TB_QE; i++) begin
						if (q_valid[i] && q_ip[i] == it.sender_ip) begin
							age = stamp - 8'd1 - q_stamp[i];
							if (best < 0 || age < best_age) begin
								best = i;
								best_age = age;
							end
						end
					end
					if (best < 0) break;
					q_valid[best] = 0;
					push_beat(arc_pkg::KIND_RELEASE, it.sender_mac, 0, 0, q_tag[best], 0);
					n++;
				end
				if (n > 0) due_beats[$].last = 1;
			end
		endfunction

		function void report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endfunction

		// Compare one result beat against the oldest outstanding prediction.
		function void check_beat(arp_beat_t got);
			arp_beat_t w;
			beats_seen++;
			if (due_beats.size() == 0) begin
				report($sformatf("unexpected beat kind %0d tag %0h", got.kind, got.tag));
				return;
			end
			w = due_beats.pop_front();
			kind_seen[w.kind]++;
			if (got.kind != w.kind)
				report($sformatf("out_kind %0d, want %0d", got.kind, w.kind));
			if (got.mac !== w.mac)
				report($sformatf("dst_mac %h, want %h", got.mac, w.mac));
			if (got.tip !== w.tip)
				report($sformatf("arp_target_ip %h, want %h", got.tip, w.tip));
			if (got.sip !== w.sip)
				report($sformatf("arp_source_ip %h, want %h", got.sip, w.sip));
			if (got.tag !== w.tag)
				report($sformatf("release_tag %h, want %h", got.tag, w.tag));
			if (got.last !== w.last)
				report($sformatf("last %b, want %b", got.last, w.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [47:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic [15:0] arp_op;
	logic [47:0] sender_mac;
	logic [31:0] sender_ip;
	logic [31:0] target_ip;
	logic [31:0] lookup_ip;
	logic [TB_TAG_W-1:0] packet_tag;
	logic out_valid;
	logic out_stall;
	logic [2:0] out_kind;
	logic [47:0] dst_mac;
	logic [31:0] arp_target_ip;
	logic [31:0] arp_source_ip;
	logic [TB_TAG_W-1:0] release_tag;
	logic last;

	arp_resolver_cache dut (.*);

	arp_cache_board board = new();
	logic [31:0] ip_pool [24];
	int hold_left = 0;
	int rx_cycle = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver stall pattern, with one long hold-off set by the test sequence.
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			case ((rx_cycle / 97) % 4)
				0: out_stall = 1'b0;
				1: out_stall = $urandom_range(0, 1);
				2: out_stall = ($urandom_range(0, 3) == 0);
				default: out_stall = ((rx_cycle % 13) < 6);
			endcase
		end
	end

	always @(posedge clk) begin
		arp_beat_t b;
		if (arst_n && out_valid && !out_stall) begin
			b.kind = arc_pkg::kind_t'(out_kind);
			b.mac = dst_mac;
			b.tip = arp_target_ip;
			b.sip = arp_source_ip;
			b.tag = release_tag;
			b.last = last;
			board.check_beat(b);
		end
	end

	// Watchdog: end the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 5000) begin
			$display("watchdog expired at %0t", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_cfg(logic [1:0] idx, logic [47:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(logic [31:0] ip, logic [47:0] mac, bit ipv);
		write_cfg(arc_pkg::REG_OWN_IP, {16'h0, ip});
		write_cfg(arc_pkg::REG_OWN_MAC, mac);
		write_cfg(arc_pkg::REG_IP_VALID, {47'h0, ipv});
	endtask

	// Wait for every predicted beat, then let a silent item finish.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.due_beats.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Present one beat; valid stays high, the caller lowers it for a gap.
	task automatic send(arp_item_t it);
		@(negedge clk);
		in_valid = 1'b1;
		req_type = it.req_type;
		arp_op = it.arp_op;
		sender_mac = it.sender_mac;
		sender_ip = it.sender_ip;
		target_ip = it.target_ip;
		lookup_ip = it.lookup_ip;
		packet_tag = it.packet_tag;
		do @(posedge clk); while (in_stall);
		board.note_item(it);
	endtask

	function automatic logic [47:0] rand_mac();
		return {$urandom, $urandom};
	endfunction

	function automatic arp_item_t noise_fill();
		arp_item_t it;
		it.req_type = $urandom_range(0, 1);
		it.arp_op = $urandom;
		it.sender_mac = rand_mac();
		it.sender_ip = $urandom;
		it.target_ip = $urandom;
		it.lookup_ip = $urandom;
		it.packet_tag = $urandom;
		return it;
	endfunction

	function automatic arp_item_t make_lookup(logic [31:0] ip, logic [TB_TAG_W-1:0] tag);
		arp_item_t it = noise_fill();
		it.req_type = 1'b1;
		it.lookup_ip = ip;
		it.packet_tag = tag;
		return it;
	endfunction

	function automatic arp_item_t make_arp(logic [15:0] op, logic [47:0] mac, logic [31:0] sip,
			logic [31:0] tip);
		arp_item_t it = noise_fill();
		it.req_type = 1'b0;
		it.arp_op = op;
		it.sender_mac = mac;
		it.sender_ip = sip;
		it.target_ip = tip;
		return it;
	endfunction

	function automatic logic [31:0] pick_ip();
		if ($urandom_range(0, 99) < 85) return ip_pool[$urandom_range(0, 23)];
		return $urandom;
	endfunction

	function automatic arp_item_t random_item();
		int roll = $urandom_range(0, 99);
		if (roll < 45) return make_lookup(pick_ip(), $urandom);
		if (roll < 72) return make_arp(arc_pkg::OP_REPLY, rand_mac(), pick_ip(), $urandom);
		if (roll < 90)
			return make_arp(arc_pkg::OP_REQUEST, rand_mac(), pick_ip(),
				($urandom_range(0, 4) != 0) ? board.own_ip : pick_ip());
		return make_arp($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(3, 4)),
			rand_mac(), pick_ip(), $urandom);
	endfunction

	task automatic random_phase(int count);
		int left = count;
		int burst;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				send(random_item());
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = arc_pkg::REG_OWN_IP;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		arp_op = '0;
		sender_mac = '0;
		sender_ip = '0;
		target_ip = '0;
		lookup_ip = '0;
		packet_tag = '0;
		out_stall = 1'b0;
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		ip_pool[0] = 32'h0;
		ip_pool[1] = 32'hffff_ffff;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Own address not valid yet: refuse misses, ignore requests, still learn replies.
		send(make_lookup(ip_pool[2], 8'h00));
		send(make_arp(arc_pkg::OP_REQUEST, rand_mac(), ip_pool[3], 32'h0));
		send(make_arp(arc_pkg::OP_REPLY, 48'hffff_ffff_ffff, ip_pool[2], 32'h0));
		send(make_lookup(ip_pool[2], 8'hff));
		send(make_arp(16'h0000, rand_mac(), ip_pool[4], 32'h0));
		drain();
		set_config(32'hffff_ffff, 48'h0, 1'b1);

		// Fill the queue with duplicate misses, overflow it, then release newest first.
		for (int i = 0; i < 3; i++) send(make_lookup(ip_pool[1], 8'(8'h10 + i)));
		for (int i = 0; i < 5; i++) send(make_lookup(ip_pool[0], 8'(8'h20 + i)));
		send(make_lookup(ip_pool[5], 8'h7f));
		send(make_arp(arc_pkg::OP_REPLY, 48'h0, ip_pool[0], 32'hffff_ffff));
		send(make_arp(arc_pkg::OP_REPLY, rand_mac(), ip_pool[1], 32'h0));
		send(make_arp(arc_pkg::OP_REQUEST, 48'hffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		send(make_arp(arc_pkg::OP_REQUEST, rand_mac(), ip_pool[6], 32'h1234_5678));
		send(make_arp(16'h0003, rand_mac(), ip_pool[6], 32'hffff_ffff));
		send(make_arp(16'hffff, rand_mac(), ip_pool[6], 32'hffff_ffff));
		send(make_lookup(ip_pool[1], 8'h55));
		send(make_lookup(32'hffff_ffff, 8'haa));
		// Update an existing entry in place, then read it back.
		send(make_arp(arc_pkg::OP_REPLY, 48'h0000_0000_0001, ip_pool[1], 32'h0));
		send(make_lookup(ip_pool[1], 8'h01));
		drain();

		set_config(32'h0, 48'hffff_ffff_ffff, 1'b1);
		random_phase(120);
		drain();
		set_config($urandom, rand_mac(), 1'b0);
		random_phase(100);
		drain();
		set_config(ip_pool[7], rand_mac(), 1'b1);
		hold_left = 400;
		random_phase(130);
		drain();
		set_config($urandom, rand_mac(), 1'b1);
		random_phase(110);
		drain();

		if (board.due_beats.size() != 0)
			board.report($sformatf("%0d predicted beats never arrived", board.due_beats.size()));
		$display("Covered %0d items and %0d result beats over six address settings.",
			board.items_seen, board.beats_seen);
		$display("Beats by kind: hit %0d queued %0d full %0d refused %0d reply %0d release %0d",
			board.kind_seen[arc_pkg::KIND_HIT], board.kind_seen[arc_pkg::KIND_QUEUED],
			board.kind_seen[arc_pkg::KIND_FULL], board.kind_seen[arc_pkg::KIND_REFUSED],
			board.kind_seen[arc_pkg::KIND_REPLY], board.kind_seen[arc_pkg::KIND_RELEASE]);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
